// ===== rtl/pfe_pkg.sv =====
// Package for the postfix expression evaluator: shared data width,
// character codes, status codes and the sequencer state type.
// No dependencies.
package pfe_pkg;

   localparam int DATA_W = 32;
   localparam int CH_W   = 8;

   // Character codes of the postfix text
   localparam logic [CH_W-1:0] CH_END   = 8'h00;
   localparam logic [CH_W-1:0] CH_DIG0  = 8'h30;
   localparam logic [CH_W-1:0] CH_DIG9  = 8'h39;
   localparam logic [CH_W-1:0] CH_PLUS  = 8'h2b;
   localparam logic [CH_W-1:0] CH_MINUS = 8'h2d;
   localparam logic [CH_W-1:0] CH_TIMES = 8'h2a;
   localparam logic [CH_W-1:0] CH_DIV   = 8'h2f;

   // Status reported with each result
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_UNDER   = 2'd1,
      STATUS_OVER    = 2'd2,
      STATUS_DIVZERO = 2'd3
   } status_type;

   // Sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_OPER = 4'b0100,
      ST_DIV  = 4'b1000
   } state_type;

endpackage

// ===== rtl/pfe_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pfe_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pfe_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on pfe_pkg.
module pfe_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pfe_pkg::DATA_W-1:0]  dividend,
   input  logic [pfe_pkg::DATA_W-1:0]  divisor,
   output logic                        done,
   output logic [pfe_pkg::DATA_W-1:0]  quotient
);

   localparam int W     = pfe_pkg::DATA_W;
   localparam int CNT_W = $clog2(W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             neg_ff, neg_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     dvs_ff, dvs_in;
   logic [W:0]       shifted;
   logic [W:0]       trial;

   // Shift in the next dividend bit and try a subtract
   assign shifted = {rem_ff, quo_ff[W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         // Load magnitudes and the result sign
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = dividend[W-1] ^ divisor[W-1];
         rem_in  = '0;
         quo_in  = dividend[W-1] ? (W'(0) - dividend) : dividend;
         dvs_in  = divisor[W-1] ? (W'(0) - divisor) : divisor;
      end else if (busy_ff) begin
         // One restoring step
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (W'(0) - quo_ff) : quo_ff;

endmodule

// ===== rtl/postfix_expression_evaluator.sv =====
// Postfix expression evaluator with the operand stack in a registered-read RAM.
// Digits and separators are taken in IDLE; +, - and * pass through EXEC and OPER
// (one RAM read of the first operand); / then waits in DIV for the bit-serial divider.
// An end character passes through EXEC and waits there for the result register to free.
// Synchronous active-high reset clears control state; stack RAM is not cleared.
module postfix_expression_evaluator #(
   parameter int STACK_DEPTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_ch,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [pfe_pkg::DATA_W-1:0]  rsp_value,
   output logic [1:0]                         rsp_status
);

   localparam int W      = pfe_pkg::DATA_W;
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int SP_W   = $clog2(STACK_DEPTH + 1);

   pfe_pkg::state_type  state_ff, state_in;
   pfe_pkg::status_type err_ff, err_in;
   logic [SP_W-1:0]     sp_ff, sp_in;
   logic                active_ff, active_in;
   logic [W-1:0]        pending_ff, pending_in;
   logic [W-1:0]        tos_ff, tos_in;
   logic [7:0]          ch_ff, ch_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]        rsp_value_ff, rsp_value_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;

   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic                ram_rd_en;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [W-1:0]        ram_rd_data;
   logic                div_start;
   logic                div_done;
   logic [W-1:0]        div_quotient;
   logic [SP_W-1:0]     sp_less1;
   logic [SP_W-1:0]     sp_less2;
   logic                out_free;
   logic                is_digit;
   logic [W-1:0]        digit_val;

   // Keep the first error of an expression
   function automatic pfe_pkg::status_type note_error(
      input pfe_pkg::status_type cur,
      input pfe_pkg::status_type code
   );
      return (cur == pfe_pkg::STATUS_OK) ? code : cur;
   endfunction

   assign sp_less1  = sp_ff - SP_W'(1);
   assign sp_less2  = sp_ff - SP_W'(2);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_digit  = req_ch inside {[pfe_pkg::CH_DIG0:pfe_pkg::CH_DIG9]};
   assign digit_val = W'(req_ch - pfe_pkg::CH_DIG0);
   assign req_stall = (state_ff != pfe_pkg::ST_IDLE);

   // Stack entries below the top; the top itself lives in tos_ff
   pfe_ram #(
      .WIDTH (W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (tos_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pfe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ram_rd_data),
      .divisor  (tos_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      err_in        = err_ff;
      sp_in         = sp_ff;
      active_in     = active_ff;
      pending_in    = pending_ff;
      tos_in        = tos_ff;
      ch_in         = ch_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = sp_less1[ADDR_W-1:0];
      ram_rd_en     = 1'b0;
      ram_rd_addr   = sp_less2[ADDR_W-1:0];
      div_start     = 1'b0;

      case (state_ff)
         pfe_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (is_digit) begin
                  // Accumulate the pending number: times ten plus digit
                  pending_in = (pending_ff << 3) + (pending_ff << 1) + digit_val;
                  active_in  = 1'b1;
               end else begin
                  ch_in = req_ch;
                  // Push a pending number, spilling the old top into the RAM
                  if (active_ff) begin
                     if (sp_ff == SP_W'(STACK_DEPTH)) begin
                        err_in = note_error(err_ff, pfe_pkg::STATUS_OVER);
                     end else begin
                        ram_wr_en = (sp_ff != '0);
                        tos_in    = pending_ff;
                        sp_in     = sp_ff + SP_W'(1);
                     end
                     pending_in = '0;
                     active_in  = 1'b0;
                  end
                  if (req_ch == pfe_pkg::CH_END || req_ch == pfe_pkg::CH_PLUS ||
                      req_ch == pfe_pkg::CH_MINUS || req_ch == pfe_pkg::CH_TIMES ||
                      req_ch == pfe_pkg::CH_DIV) begin
                     state_in = pfe_pkg::ST_EXEC;
                  end
               end
            end
         end

         pfe_pkg::ST_EXEC: begin
            if (ch_ff == pfe_pkg::CH_END) begin
               // Deliver the top and clear for the next expression
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  if (sp_ff == '0) begin
                     rsp_value_in  = '0;
                     rsp_status_in = note_error(err_ff, pfe_pkg::STATUS_UNDER);
                  end else begin
                     rsp_value_in  = tos_ff;
                     rsp_status_in = err_ff;
                  end
                  sp_in    = '0;
                  err_in   = pfe_pkg::STATUS_OK;
                  state_in = pfe_pkg::ST_IDLE;
               end
            end else if (sp_ff < SP_W'(2)) begin
               err_in   = note_error(err_ff, pfe_pkg::STATUS_UNDER);
               state_in = pfe_pkg::ST_IDLE;
            end else begin
               // Fetch the left operand
               ram_rd_en = 1'b1;
               state_in  = pfe_pkg::ST_OPER;
            end
         end

         pfe_pkg::ST_OPER: begin
            state_in = pfe_pkg::ST_IDLE;
            sp_in    = sp_less1;
            case (ch_ff)
               pfe_pkg::CH_PLUS:  tos_in = ram_rd_data + tos_ff;
               pfe_pkg::CH_MINUS: tos_in = ram_rd_data - tos_ff;
               pfe_pkg::CH_TIMES: tos_in = ram_rd_data * tos_ff;
               default: begin
                  if (tos_ff == '0) begin
                     err_in = note_error(err_ff, pfe_pkg::STATUS_DIVZERO);
                     tos_in = '0;
                  end else begin
                     // Hold the stack until the quotient is ready
                     div_start = 1'b1;
                     sp_in     = sp_ff;
                     state_in  = pfe_pkg::ST_DIV;
                  end
               end
            endcase
         end

         pfe_pkg::ST_DIV: begin
            if (div_done) begin
               tos_in   = div_quotient;
               sp_in    = sp_less1;
               state_in = pfe_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = pfe_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfe_pkg::ST_IDLE;
         err_ff       <= pfe_pkg::STATUS_OK;
         sp_ff        <= '0;
         active_ff    <= 1'b0;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         err_ff       <= err_in;
         sp_ff        <= sp_in;
         active_ff    <= active_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      tos_ff        <= tos_in;
      ch_ff         <= ch_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

`ifndef NO_ASSERTIONS
   // Stack pointer never passes the stack depth
   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("stack pointer beyond depth");

   // Quotient arrives only while the sequencer waits for it
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == pfe_pkg::ST_DIV)
      else $error("divider done outside divide state");

   // A new transaction on the result side comes only from the end step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == pfe_pkg::ST_EXEC))
      else $error("result raised outside end step");

   // Stack and status are cleared after a result is issued
   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (sp_ff == '0 && err_ff == pfe_pkg::STATUS_OK))
      else $error("state not cleared after end of expression");
`endif

endmodule
